@@ design/wkc_pkg.sv @@
// ----------------------------------------------------------------------------
// wkc_pkg
// shared constants, types and state codes of the window kernel convolution
// ----------------------------------------------------------------------------
package wkc_pkg;

   localparam int MAX_KERNEL   = 5;
   localparam int MAX_WIDTH    = 1024;
   localparam int COEFF_BITS   = 12;
   localparam int ROW_LIMIT    = 4096;
   localparam int PIX_MAX      = 255;
   localparam int RING         = (MAX_KERNEL - 1) * MAX_WIDTH + MAX_KERNEL;
   localparam int ADDR_BITS    = $clog2(RING);
   localparam int ACC_BITS     = 26;
   localparam int DIVISOR_BITS = 17;
   localparam int OUT_BITS     = 25;
   localparam int DIV_STEPS    = 25;
   localparam int KROW_BITS    = MAX_KERNEL * COEFF_BITS;

   typedef struct packed {
      logic                              start;
      logic signed [ACC_BITS-1:0]        dividend;
      logic signed [DIVISOR_BITS-1:0]    divisor;
   } wkc_div_req_type;

   typedef struct packed {
      logic                              done;
      logic signed [ACC_BITS-1:0]        quotient;
   } wkc_div_rsp_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_BREAD = 7'b0000010,
      S_BWAIT = 7'b0000100,
      S_MAC   = 7'b0001000,
      S_FLUSH = 7'b0010000,
      S_DIV   = 7'b0100000,
      S_OUT   = 7'b1000000
   } wkc_state_type;

endpackage

@@ design/window_kernel_convolution.sv @@
// ----------------------------------------------------------------------------
// window_kernel_convolution
// raster pixel filter with a normalized square kernel over a pixel ring memory
// ----------------------------------------------------------------------------
// channel   dir   fields
// req_*     in    tuser: func; tdata: pixel_in[7:0]
// rsp_*     out   tlast: frame_last; tdata: pixel_out[24:0]
// csr_*     in    we, addr 0..7, wdata up to 60 bits
//
// an item that yields nothing is done in the accept step; a border result does one ring read,
// an interior result one ring read per tap and a 25-step divide
// a register write starts a sweep over the coefficient rows for the coefficient sum, during
// which no item is taken
// reset is synchronous; the ring is not cleared
// the result register frees the sequencer, a stalled rsp side blocks only the
// next result
module window_kernel_convolution (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [0:0]  req_tuser,   // func
   input  logic [7:0]  req_tdata,   // pixel_in[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic        rsp_tlast,   // frame_last
   output logic [31:0] rsp_tdata,   // pixel_out[24:0], zeros above
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [59:0] csr_wdata
);
   import wkc_pkg::*;

   localparam logic [2:0] REG_KSIZE  = 3'd0;
   localparam logic [2:0] REG_WIDTH  = 3'd1;
   localparam logic [2:0] REG_HEIGHT = 3'd2;
   localparam logic [2:0] REG_KROW0  = 3'd3;

   // configuration
   logic [2:0]            ksize_ff;
   logic [10:0]           width_ff;
   logic [12:0]           height_ff;
   logic [KROW_BITS-1:0]  krow_ff [MAX_KERNEL];
   logic signed [DIVISOR_BITS-1:0] divisor_ff, divisor_in;

   // coefficient sum sweep
   logic                  sum_busy_ff, sum_busy_in;
   logic [2:0]            dr_ff, dr_in, dc_ff, dc_in;
   logic signed [DIVISOR_BITS-1:0] sum_ff, sum_in, sum_next;
   logic signed [COEFF_BITS-1:0]   sum_coeff;

   // effective config
   logic [2:0]  eff_k;
   logic [10:0] eff_w;
   logic [12:0] eff_h;
   logic [1:0]  half;
   logic [11:0] lag;

   // stream state
   wkc_state_type          state_ff, state_in;
   logic [ADDR_BITS-1:0]   wr_pos_ff, wr_pos_in;
   logic [ADDR_BITS-1:0]   pending_ff, pending_in;
   logic [11:0]            out_row_ff, out_row_in;
   logic [9:0]             out_col_ff, out_col_in;

   // sequencer datapath
   logic [ADDR_BITS-1:0]   base_ff, base_in;
   logic [ADDR_BITS-1:0]   addr_ff, addr_in;
   logic [ADDR_BITS-1:0]   row_start_ff, row_start_in;
   logic [2:0]             i_ff, i_in, j_ff, j_in;
   logic signed [COEFF_BITS-1:0] coeff_d1_ff, coeff_d1_in;
   logic                   v1_ff, v1_in, v2_ff, v2_in;
   logic signed [COEFF_BITS+8:0] prod_ff, prod_in;
   logic signed [ACC_BITS-1:0]   acc_ff, acc_in;
   logic signed [OUT_BITS-1:0]   result_ff, result_in;
   logic                   flast_ff, flast_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic signed [OUT_BITS-1:0]   rsp_data_ff, rsp_data_in;

   // accept-time helpers
   logic                   req_fire, is_pix, emit_now, interior, out_free;
   logic [ADDR_BITS-1:0]   wr_next, pend_inc, wr_sel, pend_sel, base_now, start_now;
   logic [ADDR_BITS:0]     diff, sdiff, row_sum;
   logic [ADDR_BITS-1:0]   row_next, addr_next;
   logic                   frame_last_now;

   // memory and divider
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_raddr;
   logic [7:0]             ram_rdata;
   wkc_div_req_type        div_req;
   wkc_div_rsp_type        div_rsp;

   wkc_ring_ram #(
      .DEPTH     (RING),
      .WIDTH     (8),
      .ADDR_BITS (ADDR_BITS)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .waddr (wr_pos_ff),
      .wdata (req_tdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   wkc_divider u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // effective register values
   always_comb begin
      unique case (ksize_ff)
         3'd0, 3'd1, 3'd2: eff_k = 3'd1;
         3'd3, 3'd4:       eff_k = 3'd3;
         default:          eff_k = 3'(MAX_KERNEL);
      endcase
      if (width_ff == 11'd0) begin
         eff_w = 11'd1;
      end else if (width_ff > 11'(MAX_WIDTH)) begin
         eff_w = 11'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == 13'd0) begin
         eff_h = 13'd1;
      end else if (height_ff > 13'(ROW_LIMIT)) begin
         eff_h = 13'(ROW_LIMIT);
      end else begin
         eff_h = height_ff;
      end
      half = eff_k[2:1];
      lag  = 12'({10'd0, half} * {1'b0, eff_w}) + {10'd0, half};
   end

   // coefficient sum sweep
   always_comb begin
      sum_coeff   = signed'(krow_ff[dr_ff][dc_ff*COEFF_BITS +: COEFF_BITS]);
      sum_next    = sum_ff + ((dr_ff < eff_k && dc_ff < eff_k) ?
                              DIVISOR_BITS'(sum_coeff) : DIVISOR_BITS'(0));
      sum_busy_in = sum_busy_ff;
      dr_in       = dr_ff;
      dc_in       = dc_ff;
      sum_in      = sum_ff;
      divisor_in  = divisor_ff;
      if (csr_we) begin
         sum_busy_in = 1'b1;
         dr_in       = '0;
         dc_in       = '0;
         sum_in      = '0;
      end else if (sum_busy_ff) begin
         sum_in = sum_next;
         if (dc_ff == 3'(MAX_KERNEL - 1)) begin
            dc_in = '0;
            dr_in = dr_ff + 3'd1;
            if (dr_ff == 3'(MAX_KERNEL - 1)) begin
               sum_busy_in = 1'b0;
               divisor_in  = (sum_next == '0) ? DIVISOR_BITS'(1) : sum_next;
            end
         end else begin
            dc_in = dc_ff + 3'd1;
         end
      end
   end

   // sequencer
   always_comb begin
      req_tready = (state_ff == S_IDLE) && !sum_busy_ff;
      req_fire   = req_tvalid && req_tready;
      is_pix     = !req_tuser[0];
      ram_we     = req_fire && is_pix;

      wr_next  = (wr_pos_ff == ADDR_BITS'(RING - 1)) ? '0 : wr_pos_ff + 1'b1;
      pend_inc = pending_ff + 1'b1;
      wr_sel   = is_pix ? wr_next : wr_pos_ff;
      pend_sel = is_pix ? pend_inc : pending_ff;
      emit_now = is_pix ? (pend_inc > {1'b0, lag}) : (pending_ff != '0);
      diff     = {1'b0, wr_sel} - {1'b0, pend_sel};
      base_now = diff[ADDR_BITS] ? ADDR_BITS'(diff + (ADDR_BITS+1)'(RING))
                                 : diff[ADDR_BITS-1:0];
      sdiff    = {1'b0, base_now} - {2'b0, lag};
      start_now = sdiff[ADDR_BITS] ? ADDR_BITS'(sdiff + (ADDR_BITS+1)'(RING))
                                   : sdiff[ADDR_BITS-1:0];
      interior = ({1'b0, out_row_ff} >= {11'd0, half}) &&
                 ({1'b0, out_row_ff} + {11'd0, half} < eff_h) &&
                 ({1'b0, out_col_ff} >= {9'd0, half}) &&
                 ({1'b0, out_col_ff} + {9'd0, half} < eff_w);
      frame_last_now = ({1'b0, out_row_ff} + 13'd1 >= eff_h) &&
                       ({1'b0, out_col_ff} + 11'd1 >= eff_w);

      row_sum   = {1'b0, row_start_ff} + {3'd0, eff_w[9:0] == 10'd0 ?
                                          eff_w : eff_w};
      row_next  = (row_sum >= (ADDR_BITS+1)'(RING)) ?
                  ADDR_BITS'(row_sum - (ADDR_BITS+1)'(RING)) : row_sum[ADDR_BITS-1:0];
      addr_next = (addr_ff == ADDR_BITS'(RING - 1)) ? '0 : addr_ff + 1'b1;

      out_free = !rsp_valid_ff || rsp_tready;

      state_in     = state_ff;
      wr_pos_in    = wr_pos_ff;
      pending_in   = pending_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      base_in      = base_ff;
      addr_in      = addr_ff;
      row_start_in = row_start_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      coeff_d1_in  = coeff_d1_ff;
      v1_in        = 1'b0;
      v2_in        = v1_ff;
      prod_in      = signed'({1'b0, ram_rdata}) * coeff_d1_ff;
      acc_in       = v2_ff ? acc_ff + ACC_BITS'(prod_ff) : acc_ff;
      result_in    = result_ff;
      flast_in     = flast_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      ram_raddr    = (state_ff == S_MAC) ? addr_ff : base_ff;
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = divisor_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (is_pix) begin
                  wr_pos_in  = wr_next;
                  pending_in = pend_inc;
               end
               if (emit_now) begin
                  pending_in   = pend_sel - 1'b1;
                  base_in      = base_now;
                  addr_in      = start_now;
                  row_start_in = start_now;
                  i_in         = '0;
                  j_in         = '0;
                  acc_in       = '0;
                  flast_in     = frame_last_now;
                  if ({1'b0, out_col_ff} + 11'd1 >= eff_w) begin
                     out_col_in = '0;
                     out_row_in = ({1'b0, out_row_ff} + 13'd1 >= eff_h) ? '0
                                  : out_row_ff + 12'd1;
                  end else begin
                     out_col_in = out_col_ff + 10'd1;
                  end
                  state_in = interior ? S_MAC : S_BREAD;
               end
            end
         end
         S_BREAD: begin
            state_in = S_BWAIT;
         end
         S_BWAIT: begin
            result_in = OUT_BITS'(ram_rdata);
            state_in  = S_OUT;
         end
         S_MAC: begin
            coeff_d1_in = signed'(krow_ff[i_ff][j_ff*COEFF_BITS +: COEFF_BITS]);
            v1_in       = 1'b1;
            if (j_ff == eff_k - 3'd1) begin
               j_in         = '0;
               i_in         = i_ff + 3'd1;
               row_start_in = row_next;
               addr_in      = row_next;
               if (i_ff == eff_k - 3'd1) begin
                  state_in = S_FLUSH;
               end
            end else begin
               j_in    = j_ff + 3'd1;
               addr_in = addr_next;
            end
         end
         S_FLUSH: begin
            if (!v1_ff && !v2_ff) begin
               div_req.start = 1'b1;
               state_in      = S_DIV;
            end
         end
         S_DIV: begin
            if (div_rsp.done) begin
               result_in = (div_rsp.quotient > ACC_BITS'(PIX_MAX)) ?
                           OUT_BITS'(PIX_MAX) : div_rsp.quotient[OUT_BITS-1:0];
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = flast_ff;
               rsp_data_in  = result_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ksize_ff     <= 3'd3;
         width_ff     <= 11'd1024;
         height_ff    <= 13'd1024;
         for (int r = 0; r < MAX_KERNEL; r++) begin
            krow_ff[r] <= (r == 1) ? KROW_BITS'(1 << COEFF_BITS) : '0;
         end
         divisor_ff   <= DIVISOR_BITS'(1);
         sum_busy_ff  <= 1'b0;
         state_ff     <= S_IDLE;
         wr_pos_ff    <= '0;
         pending_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               REG_KSIZE:  ksize_ff  <= csr_wdata[2:0];
               REG_WIDTH:  width_ff  <= csr_wdata[10:0];
               REG_HEIGHT: height_ff <= csr_wdata[12:0];
               default:    krow_ff[csr_addr - REG_KROW0] <= csr_wdata;
            endcase
         end
         divisor_ff   <= divisor_in;
         sum_busy_ff  <= sum_busy_in;
         state_ff     <= state_in;
         wr_pos_ff    <= wr_pos_in;
         pending_ff   <= pending_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dr_ff        <= dr_in;
      dc_ff        <= dc_in;
      sum_ff       <= sum_in;
      base_ff      <= base_in;
      addr_ff      <= addr_in;
      row_start_ff <= row_start_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      coeff_d1_ff  <= coeff_d1_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      result_ff    <= result_in;
      flast_ff     <= flast_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(32 - OUT_BITS){1'b0}}, rsp_data_ff};

   a_pending_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff < ADDR_BITS'(RING))
      else $error("pending count beyond ring depth");

   a_div_after_mac: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (!v1_ff && !v2_ff && state_ff == S_FLUSH))
      else $error("divider started with products in flight");

   a_sweep_blocks: assert property (@(posedge clock) disable iff (reset)
      sum_busy_ff |-> !req_tready)
      else $error("item taken during coefficient sum sweep");

   a_out_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && out_free) |=> (rsp_tvalid && state_ff == S_IDLE))
      else $error("result not loaded into output register");

endmodule

@@ design/wkc_ring_ram.sv @@
// ----------------------------------------------------------------------------
// wkc_ring_ram
// single write port, single registered read port memory for the pixel ring
// ----------------------------------------------------------------------------
module wkc_ring_ram #(
   parameter int DEPTH     = 4101,
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

@@ design/wkc_divider.sv @@
// ----------------------------------------------------------------------------
// wkc_divider
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module wkc_divider (
   input  logic                     clock,
   input  logic                     reset,
   input  wkc_pkg::wkc_div_req_type req,
   output wkc_pkg::wkc_div_rsp_type rsp
);
   import wkc_pkg::*;

   localparam int MAG_BITS = OUT_BITS;

   logic                      busy_ff, busy_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic [MAG_BITS-1:0]       dvd_ff, dvd_in;
   logic [MAG_BITS-1:0]       quo_ff, quo_in;
   logic [DIVISOR_BITS:0]     rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]   dvs_ff, dvs_in;
   logic                      neg_ff, neg_in;
   logic                      done_ff, done_in;
   logic signed [ACC_BITS-1:0] q_ff, q_in;
   logic [DIVISOR_BITS:0]     rem_sh;
   logic                      qbit;
   logic [ACC_BITS-1:0]       dvd_abs;
   logic [DIVISOR_BITS-1:0]   dvs_abs;
   logic signed [ACC_BITS-1:0] q_mag;

   always_comb begin
      dvd_abs = req.dividend[ACC_BITS-1] ? ACC_BITS'(-req.dividend) : req.dividend;
      dvs_abs = req.divisor[DIVISOR_BITS-1] ? DIVISOR_BITS'(-req.divisor) : req.divisor;
      rem_sh  = {rem_ff[DIVISOR_BITS-1:0], dvd_ff[MAG_BITS-1]};
      qbit    = (rem_sh >= {1'b0, dvs_ff});
      // magnitude including the bit found in this step
      q_mag   = signed'({1'b0, quo_ff[MAG_BITS-2:0], qbit});

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      q_in    = q_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dvd_abs[MAG_BITS-1:0];
         quo_in  = '0;
         rem_in  = '0;
         dvs_in  = dvs_abs;
         neg_in  = req.dividend[ACC_BITS-1] ^ req.divisor[DIVISOR_BITS-1];
      end else if (busy_ff) begin
         rem_in = qbit ? (rem_sh - {1'b0, dvs_ff}) : rem_sh;
         dvd_in = {dvd_ff[MAG_BITS-2:0], 1'b0};
         quo_in = {quo_ff[MAG_BITS-2:0], qbit};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            q_in    = neg_ff ? -q_mag : q_mag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      q_ff   <= q_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = q_ff;

endmodule
